### hdl/fcpq_pkg.sv
// ---------------------------------------------------------------------------
// fcpq_pkg
// Shared constants and types for the four-class priority queue.
// ---------------------------------------------------------------------------
package fcpq_pkg;

   localparam int CLASS_DEPTH = 16;
   localparam int ID_WIDTH    = 16;
   localparam int NUM_CLASSES = 4;

   localparam int FIELD_ID_W  = 16;
   localparam int CLS_W       = 2;
   localparam int IDX_W       = $clog2(CLASS_DEPTH);
   localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [CLS_W-1:0] CLS_ELDERLY  = 2'd0;
   localparam logic [CLS_W-1:0] CLS_DISABLED = 2'd1;
   localparam logic [CLS_W-1:0] CLS_PREGNANT = 2'd2;
   localparam logic [CLS_W-1:0] CLS_NORMAL   = 2'd3;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ID_WIDTH-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic             served_valid;
      logic [CLS_W-1:0] served_class;
      logic             any_waiting;
      logic             dropped;
   } result_type;

endpackage

### hdl/fcpq_ram.sv
// ---------------------------------------------------------------------------
// fcpq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module fcpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/fcpq_ctrl.sv
// ---------------------------------------------------------------------------
// fcpq_ctrl
// Per-class head/count bookkeeping, class select and store addressing.
// ---------------------------------------------------------------------------
module fcpq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            mode,
   input  logic [fcpq_pkg::FIELD_ID_W-1:0] entry_id,
   input  logic                            preferential,
   input  logic                            disabled_flag,
   input  logic                            pregnant_flag,
   output fcpq_pkg::mem_req_type           mem_req,
   output fcpq_pkg::result_type            result
);

   logic [fcpq_pkg::IDX_W-1:0] head_ff  [fcpq_pkg::NUM_CLASSES];
   logic [fcpq_pkg::IDX_W-1:0] head_in  [fcpq_pkg::NUM_CLASSES];
   logic [fcpq_pkg::CNT_W-1:0] count_ff [fcpq_pkg::NUM_CLASSES];
   logic [fcpq_pkg::CNT_W-1:0] count_in [fcpq_pkg::NUM_CLASSES];

   always_comb begin
      logic [fcpq_pkg::CLS_W-1:0] enq_cls;
      logic [fcpq_pkg::CLS_W-1:0] deq_cls;
      logic                       found;
      logic [fcpq_pkg::CNT_W:0]   tail_sum;
      logic [fcpq_pkg::IDX_W-1:0] tail;
      logic [fcpq_pkg::IDX_W-1:0] head_sel;
      logic                       full;

      for (int k = 0; k < fcpq_pkg::NUM_CLASSES; k++) begin
         head_in[k]  = head_ff[k];
         count_in[k] = count_ff[k];
      end

      // class pick for an enqueue
      if (!preferential) begin
         enq_cls = fcpq_pkg::CLS_NORMAL;
      end else if (disabled_flag) begin
         enq_cls = fcpq_pkg::CLS_DISABLED;
      end else if (pregnant_flag) begin
         enq_cls = fcpq_pkg::CLS_PREGNANT;
      end else begin
         enq_cls = fcpq_pkg::CLS_ELDERLY;
      end

      full     = (count_ff[enq_cls] == fcpq_pkg::CNT_W'(fcpq_pkg::CLASS_DEPTH));
      tail_sum = (fcpq_pkg::CNT_W+1)'(head_ff[enq_cls])
               + (fcpq_pkg::CNT_W+1)'(count_ff[enq_cls]);
      if (tail_sum >= (fcpq_pkg::CNT_W+1)'(fcpq_pkg::CLASS_DEPTH)) begin
         tail = fcpq_pkg::IDX_W'(tail_sum - (fcpq_pkg::CNT_W+1)'(fcpq_pkg::CLASS_DEPTH));
      end else begin
         tail = fcpq_pkg::IDX_W'(tail_sum);
      end

      // strict priority: lowest nonempty class number wins
      found   = 1'b0;
      deq_cls = fcpq_pkg::CLS_ELDERLY;
      for (int k = 0; k < fcpq_pkg::NUM_CLASSES; k++) begin
         if (!found && count_ff[k] != '0) begin
            found   = 1'b1;
            deq_cls = fcpq_pkg::CLS_W'(k);
         end
      end
      head_sel = head_ff[deq_cls];

      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.wdata = fcpq_pkg::ID_WIDTH'(entry_id);
      mem_req.waddr = fcpq_pkg::ADDR_W'(enq_cls) * fcpq_pkg::ADDR_W'(fcpq_pkg::CLASS_DEPTH)
                    + fcpq_pkg::ADDR_W'(tail);
      mem_req.raddr = fcpq_pkg::ADDR_W'(deq_cls) * fcpq_pkg::ADDR_W'(fcpq_pkg::CLASS_DEPTH)
                    + fcpq_pkg::ADDR_W'(head_sel);

      result.served_valid = 1'b0;
      result.served_class = fcpq_pkg::CLS_ELDERLY;
      result.dropped      = 1'b0;

      if (mode == fcpq_pkg::MODE_ENQUEUE) begin
         if (full) begin
            result.dropped = 1'b1;
         end else begin
            mem_req.we        = accept;
            count_in[enq_cls] = count_ff[enq_cls] + 1'b1;
         end
      end else if (found) begin
         mem_req.re          = accept;
         result.served_valid = 1'b1;
         result.served_class = deq_cls;
         count_in[deq_cls]   = count_ff[deq_cls] - 1'b1;
         if (head_sel == fcpq_pkg::IDX_W'(fcpq_pkg::CLASS_DEPTH - 1)) begin
            head_in[deq_cls] = '0;
         end else begin
            head_in[deq_cls] = head_sel + 1'b1;
         end
      end

      result.any_waiting = 1'b0;
      for (int k = 0; k < fcpq_pkg::NUM_CLASSES; k++) begin
         if (count_in[k] != '0) begin
            result.any_waiting = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < fcpq_pkg::NUM_CLASSES; k++) begin
         if (reset) begin
            head_ff[k]  <= '0;
            count_ff[k] <= '0;
         end else if (accept) begin
            head_ff[k]  <= head_in[k];
            count_ff[k] <= count_in[k];
         end
      end
   end

endmodule

### hdl/four_class_priority_queue_core.sv
// ---------------------------------------------------------------------------
// four_class_priority_queue_core
// Four FIFO classes sharing one entry store, served by strict priority.
// ---------------------------------------------------------------------------
// Path: a request beat reaches the response port through stage 1 (store read) and stage 2 (out reg).
// Throughput: one request per cycle while the response side takes beats; the single store read port and the
//   per-class head/count update each handle one request per cycle.
// Reset: synchronous, active high; empties all classes and both pipe stages.
//   The entry store is not cleared; only occupied slots are ever read.
module four_class_priority_queue_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [fcpq_pkg::FIELD_ID_W-1:0] req_entry_id,
   input  logic                            req_preferential,
   input  logic                            req_disabled_flag,
   input  logic                            req_pregnant_flag,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_served_valid,
   output logic [fcpq_pkg::FIELD_ID_W-1:0] rsp_served_id,
   output logic [fcpq_pkg::CLS_W-1:0]      rsp_served_class,
   output logic                            rsp_any_waiting,
   output logic                            rsp_dropped
);

   // Stage 1 holds the result flags while the store read is in flight.
   // Stage 2 is the output register; stage 1 drains into it whenever it is
   // empty or its beat is being taken.
   logic                          accept;
   logic                          s1_move;
   fcpq_pkg::mem_req_type         mem_req;
   fcpq_pkg::result_type          result;
   logic [fcpq_pkg::ID_WIDTH-1:0] rdata;

   logic                            s1_valid_ff, s1_valid_in;
   fcpq_pkg::result_type            s1_res_ff;
   logic                            out_valid_ff, out_valid_in;
   fcpq_pkg::result_type            out_res_ff;
   logic [fcpq_pkg::FIELD_ID_W-1:0] out_id_ff, out_id_in;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   fcpq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_mode),
      .entry_id      (req_entry_id),
      .preferential  (req_preferential),
      .disabled_flag (req_disabled_flag),
      .pregnant_flag (req_pregnant_flag),
      .mem_req       (mem_req),
      .result        (result)
   );

   // Entry store: class k owns slots k*CLASS_DEPTH .. k*CLASS_DEPTH+CLASS_DEPTH-1.
   // An enqueue writes a free slot and a dequeue reads an occupied one, so
   // a read and write never hit the same slot in one cycle. Read data holds
   // while stage 1 stalls because no new read is issued then.
   fcpq_ram #(
      .WIDTH (fcpq_pkg::ID_WIDTH),
      .DEPTH (fcpq_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (rdata)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && !rsp_ready);
      // no entry served -> id reads as zero
      out_id_in    = s1_res_ff.served_valid ? fcpq_pkg::FIELD_ID_W'(rdata) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= result;
      end
      if (s1_move) begin
         out_res_ff <= s1_res_ff;
         out_id_ff  <= out_id_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_served_valid = out_res_ff.served_valid;
   assign rsp_served_id    = out_id_ff;
   assign rsp_served_class = out_res_ff.served_class;
   assign rsp_any_waiting  = out_res_ff.any_waiting;
   assign rsp_dropped      = out_res_ff.dropped;

endmodule

### hdl/fcpq_checker.sv
// ---------------------------------------------------------------------------
// fcpq_checker
// Port-level checks for the four-class priority queue, bound to the core.
// ---------------------------------------------------------------------------
module fcpq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_served_valid,
   input logic [fcpq_pkg::FIELD_ID_W-1:0] rsp_served_id,
   input logic [fcpq_pkg::CLS_W-1:0]      rsp_served_class,
   input logic                            rsp_any_waiting,
   input logic                            rsp_dropped
);

   // a beat is either a drop or a serve, never both
   a_drop_not_served: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_dropped && rsp_served_valid))
      else $error("response both dropped and served");

   // no entry served: id and class read as zero
   a_empty_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_served_valid) |->
         (rsp_served_id == '0 && rsp_served_class == fcpq_pkg::CLS_ELDERLY))
      else $error("unserved response carries id or class");

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_served_id) && $stable(rsp_served_class)
          && $stable(rsp_any_waiting) && $stable(rsp_dropped)))
      else $error("stalled response changed");

   // the cycle after reset no response may be pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // the cycle after reset the request side is open
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready right after reset");

endmodule

bind four_class_priority_queue_core fcpq_checker u_fcpq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_served_valid (rsp_served_valid),
   .rsp_served_id    (rsp_served_id),
   .rsp_served_class (rsp_served_class),
   .rsp_any_waiting  (rsp_any_waiting),
   .rsp_dropped      (rsp_dropped)
);

### test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for four_class_priority_queue_core. Enqueue and
// dequeue beats go in through a valid/ready port. A behavioral copy of the
// four strict-priority classes predicts every response beat, and each
// response is compared field by field, in order. Directed beats cover the
// routing and the corner cases. Random bursts with stalls on both sides
// follow, then a long output hold-off, more bursts, a drain and a stall-free tail.
// ---------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                            served_valid;
      logic [fcpq_pkg::FIELD_ID_W-1:0] served_id;
      logic [fcpq_pkg::CLS_W-1:0]      served_class;
      logic                            any_waiting;
      logic                            dropped;
   } queue_outcome_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_mode = fcpq_pkg::MODE_ENQUEUE;
   logic [fcpq_pkg::FIELD_ID_W-1:0] req_entry_id = '0;
   logic                            req_preferential = 1'b0;
   logic                            req_disabled_flag = 1'b0;
   logic                            req_pregnant_flag = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_served_valid;
   logic [fcpq_pkg::FIELD_ID_W-1:0] rsp_served_id;
   logic [fcpq_pkg::CLS_W-1:0]      rsp_served_class;
   logic                            rsp_any_waiting;
   logic                            rsp_dropped;

   // shadow copy of the four classes
   logic [fcpq_pkg::FIELD_ID_W-1:0] class_ids [fcpq_pkg::NUM_CLASSES][fcpq_pkg::CLASS_DEPTH];
   int                    class_head [fcpq_pkg::NUM_CLASSES] = '{default: 0};
   int                    class_fill [fcpq_pkg::NUM_CLASSES] = '{default: 0};

   queue_outcome_type     pending_outcomes [$];
   int                    mismatch_count = 0;
   int                    cycle_count = 0;

   // idle rates in percent per decision point, and the output hold-off
   int                    req_idle_pct = 0;
   int                    rsp_idle_pct = 0;
   int                    rsp_hold_cycles = 0;

   four_class_priority_queue_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_entry_id      (req_entry_id),
      .req_preferential  (req_preferential),
      .req_disabled_flag (req_disabled_flag),
      .req_pregnant_flag (req_pregnant_flag),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_served_valid  (rsp_served_valid),
      .rsp_served_id     (rsp_served_id),
      .rsp_served_class  (rsp_served_class),
      .rsp_any_waiting   (rsp_any_waiting),
      .rsp_dropped       (rsp_dropped)
   );

   always #5 clock = ~clock;

   // Applies one request beat to the shadow classes, returns its response.
   function automatic queue_outcome_type enqueue_or_serve(
         input logic mode,
         input logic [fcpq_pkg::FIELD_ID_W-1:0] id,
         input logic pref,
         input logic dis,
         input logic preg);
      queue_outcome_type outcome;
      logic [fcpq_pkg::CLS_W-1:0] cls;
      int slot;
      int total;
      outcome = '0;
      total = 0;
      if (mode == fcpq_pkg::MODE_ENQUEUE) begin
         // flags only matter on a preferential entry; disabled wins over pregnant
         if (!pref)
            cls = fcpq_pkg::CLS_NORMAL;
         else if (dis)
            cls = fcpq_pkg::CLS_DISABLED;
         else if (preg)
            cls = fcpq_pkg::CLS_PREGNANT;
         else
            cls = fcpq_pkg::CLS_ELDERLY;
         if (class_fill[cls] >= fcpq_pkg::CLASS_DEPTH) begin
            outcome.dropped = 1'b1;
         end else begin
            slot = (class_head[cls] + class_fill[cls]) % fcpq_pkg::CLASS_DEPTH;
            class_ids[cls][slot] = id;
            class_fill[cls]++;
         end
      end else begin
         // strict priority: lowest class index first
         for (int c = 0; c < fcpq_pkg::NUM_CLASSES; c++) begin
            if (!outcome.served_valid && class_fill[c] != 0) begin
               outcome.served_valid = 1'b1;
               outcome.served_id    = class_ids[c][class_head[c]];
               outcome.served_class = fcpq_pkg::CLS_W'(c);
               class_head[c]        = (class_head[c] + 1) % fcpq_pkg::CLASS_DEPTH;
               class_fill[c]--;
            end
         end
      end
      for (int c = 0; c < fcpq_pkg::NUM_CLASSES; c++)
         total += class_fill[c];
      outcome.any_waiting = (total != 0);
      return outcome;
   endfunction

   function automatic void check_field(input string name,
                                       input logic [fcpq_pkg::FIELD_ID_W-1:0] expected,
                                       input logic [fcpq_pkg::FIELD_ID_W-1:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0h, actual %0h", name, expected, actual);
         mismatch_count++;
      end
   endfunction

   // {preferential, disabled, pregnant} that route to a class; don't-care bits random
   function automatic logic [2:0] flags_for_class(input logic [fcpq_pkg::CLS_W-1:0] cls);
      logic [2:0] flags;
      case (cls)
         fcpq_pkg::CLS_ELDERLY:  flags = 3'b100;
         fcpq_pkg::CLS_DISABLED: flags = {2'b11, 1'($urandom_range(0, 1))};
         fcpq_pkg::CLS_PREGNANT: flags = 3'b101;
         default:                flags = {1'b0, 2'($urandom_range(0, 3))};
      endcase
      return flags;
   endfunction

   // Prediction on each accepted request beat, then the check of each
   // accepted response beat against the oldest prediction.
   always @(posedge clock) begin
      queue_outcome_type want;
      if (!reset && req_valid && req_ready)
         pending_outcomes.push_back(enqueue_or_serve(req_mode, req_entry_id,
                                                     req_preferential,
                                                     req_disabled_flag,
                                                     req_pregnant_flag));
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response beat with no request pending");
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("served_valid", want.served_valid, rsp_served_valid);
            check_field("served_id", want.served_id, rsp_served_id);
            check_field("served_class", want.served_class, rsp_served_class);
            check_field("any_waiting", want.any_waiting, rsp_any_waiting);
            check_field("dropped", want.dropped, rsp_dropped);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Response side: random stall bursts, plus a long hold-off on request.
   initial begin
      while (reset)
         @(posedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offers one request beat and returns at the edge that accepts it.
   // Valid is left high so back-to-back beats need no extra edge.
   task automatic send_request(input logic mode,
                               input logic [fcpq_pkg::FIELD_ID_W-1:0] id,
                               input logic pref, input logic dis, input logic preg);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_entry_id      <= id;
      req_preferential  <= pref;
      req_disabled_flag <= dis;
      req_pregnant_flag <= preg;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Random beat: enqueue with the given odds, mostly aimed at one class.
   task automatic send_mixed_request(input int enq_pct,
                                     input logic [fcpq_pkg::CLS_W-1:0] hot_class);
      logic mode;
      logic [2:0] flags;
      mode = ($urandom_range(0, 99) < enq_pct) ? fcpq_pkg::MODE_ENQUEUE
                                               : fcpq_pkg::MODE_DEQUEUE;
      if ($urandom_range(0, 99) < 60)
         flags = flags_for_class(hot_class);
      else
         flags = 3'($urandom_range(0, 7));
      send_request(mode, fcpq_pkg::FIELD_ID_W'($urandom_range(0, 16'hFFFF)),
                   flags[2], flags[1], flags[0]);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_outcomes.size() != 0);
   endtask

   task automatic test_empty_dequeue();
      send_request(fcpq_pkg::MODE_DEQUEUE, 16'hFFFF, 1'b1, 1'b1, 1'b1);
   endtask

   // Two normal, others once; first normal has both flags, disabled has pregnant.
   task automatic test_class_routing();
      send_request(fcpq_pkg::MODE_ENQUEUE, 16'hFFFF, 1'b0, 1'b1, 1'b1);
      send_request(fcpq_pkg::MODE_ENQUEUE, 16'h0000, 1'b1, 1'b1, 1'b1);
      send_request(fcpq_pkg::MODE_ENQUEUE, 16'hA5A5, 1'b1, 1'b0, 1'b1);
      send_request(fcpq_pkg::MODE_ENQUEUE, 16'h5A5A, 1'b1, 1'b0, 1'b0);
      send_request(fcpq_pkg::MODE_ENQUEUE, 16'h0001, 1'b0, 1'b0, 1'b0);
      // served elderly, disabled, pregnant, then normal in arrival order
      send_request(fcpq_pkg::MODE_DEQUEUE, 16'h1234, 1'b0, 1'b0, 1'b0);
      send_request(fcpq_pkg::MODE_DEQUEUE, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      send_request(fcpq_pkg::MODE_DEQUEUE, 16'h0000, 1'b0, 1'b1, 1'b0);
      send_request(fcpq_pkg::MODE_DEQUEUE, 16'h8000, 1'b1, 1'b0, 1'b1);
      send_request(fcpq_pkg::MODE_DEQUEUE, 16'h7FFF, 1'b0, 1'b0, 1'b1);
   endtask

   // Fill the elderly class, then one more beat that must be dropped.
   task automatic test_full_class_drop();
      for (int k = 0; k <= fcpq_pkg::CLASS_DEPTH; k++)
         send_request(fcpq_pkg::MODE_ENQUEUE, fcpq_pkg::FIELD_ID_W'(16'hE000 + k),
                      1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_random_traffic(input int item_total, input bit allow_idle);
      int sent;
      int burst_len;
      int enq_pct;
      logic [fcpq_pkg::CLS_W-1:0] hot_class;
      sent = 0;
      while (sent < item_total) begin
         burst_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0:       enq_pct = 20;
            1:       enq_pct = 50;
            default: enq_pct = 85;
         endcase
         hot_class = fcpq_pkg::CLS_W'($urandom_range(0, 3));
         if (allow_idle) begin
            req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            rsp_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (int k = 0; k < burst_len && sent < item_total; k++) begin
            send_mixed_request(enq_pct, hot_class);
            sent++;
         end
      end
   endtask

   // Output held off while requests keep coming: the core fills and backs up.
   task automatic test_output_hold_off();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_cycles = 200;
      repeat (40) send_mixed_request(50, fcpq_pkg::CLS_W'($urandom_range(0, 3)));
      wait_for_drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_dequeue();
      test_class_routing();
      test_full_class_drop();
      test_random_traffic(1000, 1'b1);
      test_output_hold_off();
      test_random_traffic(40, 1'b1);
      wait_for_drain();
      test_random_traffic(250, 1'b0);
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
